@@ hdl/lpcs_pkg.sv @@
// ----------------------------------------------------------------------------
// LED pattern color sampler package
// Payload types, pattern codes, end colors and the sine weight function.
// ----------------------------------------------------------------------------
package lpcs_pkg;

  typedef struct packed {
    logic [15:0] x_pos;
    logic [15:0] y_pos;
    logic [15:0] phase;
  } pixel_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } color_t;

  typedef struct packed {
    color_t      lo;
    color_t      hi;
    logic [16:0] weight;
  } mix_req_t;

  typedef struct packed {
    color_t lo;
    color_t hi;
  } color_pair_t;

  typedef enum logic [2:0] {
    PAT_SOLID    = 3'd0,
    PAT_GRADIENT = 3'd1,
    PAT_WAVE     = 3'd2,
    PAT_NOISE    = 3'd3,
    PAT_CHASE    = 3'd4
  } pattern_e;

  localparam logic [15:0] POS_ONE     = 16'd32768;
  localparam logic [15:0] POS_HALF    = 16'd16384;
  localparam logic [16:0] WEIGHT_ONE  = 17'd65536;
  localparam logic [31:0] HASH_X      = 32'd73856093;
  localparam logic [31:0] HASH_Y      = 32'd19349663;
  localparam logic [31:0] HASH_P      = 32'd83492791;
  localparam logic [31:0] HASH_MIX    = 32'd1274126177;
  localparam logic [23:0] PHASE_STEPS = 24'd120;
  localparam logic [19:0] CHASE_SLOPE = 20'd7;

  localparam color_t SOLID_COLOR = '{red: 16'd55705, green: 16'd1311,  blue: 16'd2621};
  localparam color_t GRAD0       = '{red: 16'd1966,  green: 16'd5243,  blue: 16'd19661};
  localparam color_t GRAD1       = '{red: 16'd60292, green: 16'd1966,  blue: 16'd4587};
  localparam color_t GRAD2       = '{red: 16'd65535, green: 16'd27525, blue: 16'd2621};
  localparam color_t WAVE0       = '{red: 16'd655,   green: 16'd3932,  blue: 16'd11796};
  localparam color_t WAVE1       = '{red: 16'd3277,  green: 16'd51117, blue: 16'd65535};
  localparam color_t NOISE0      = '{red: 16'd1966,  green: 16'd655,   blue: 16'd3277};
  localparam color_t NOISE1      = '{red: 16'd58982, green: 16'd1311,  blue: 16'd7864};
  localparam color_t CHASE0      = '{red: 16'd655,   green: 16'd655,   blue: 16'd1311};
  localparam color_t CHASE1      = '{red: 16'd65535, green: 16'd1966,  blue: 16'd3932};
  localparam color_t BLACK       = '{red: 16'd0,     green: 16'd0,     blue: 16'd0};

  // 0.5 + 0.5*sin of an angle in 1/65536 of a cycle, polynomial per quadrant
  function automatic logic [16:0] wave_weight(input logic [15:0] ang);
    logic [1:0]  quad;
    logic [13:0] rem;
    logic [14:0] u;
    logic [16:0] x;
    logic [33:0] xx;
    logic [16:0] x2;
    logic [33:0] cx;
    logic [15:0] inner;
    logic [33:0] xi;
    logic [16:0] mid;
    logic [33:0] xm;
    logic [16:0] s;
    quad  = ang[15:14];
    rem   = ang[13:0];
    u     = quad[0] ? 15'(15'd16384 - 15'(rem)) : 15'(rem);
    x     = {u, 2'b00};
    xx    = 34'(x) * 34'(x);
    x2    = xx[32:16];
    cx    = 34'(x2) * 34'd4640;
    inner = 16'(16'd42048 - cx[31:16]);
    xi    = 34'(x2) * 34'(inner);
    mid   = 17'(17'd102944 - xi[32:16]);
    xm    = 34'(x) * 34'(mid);
    s     = xm[32:16];
    if (s > WEIGHT_ONE) begin
      s = WEIGHT_ONE;
    end
    return quad[1] ? 17'(17'd32768 - 17'(s[16:1])) : 17'(17'd32768 + 17'(s[16:1]));
  endfunction

  function automatic color_pair_t color_pair(input logic [2:0] sel, input logic upper);
    color_pair_t p;
    case (sel)
      PAT_SOLID: begin
        p = '{lo: SOLID_COLOR, hi: SOLID_COLOR};
      end
      PAT_GRADIENT: begin
        p = upper ? '{lo: GRAD1, hi: GRAD2} : '{lo: GRAD0, hi: GRAD1};
      end
      PAT_WAVE: begin
        p = '{lo: WAVE0, hi: WAVE1};
      end
      PAT_NOISE: begin
        p = '{lo: NOISE0, hi: NOISE1};
      end
      PAT_CHASE: begin
        p = '{lo: CHASE0, hi: CHASE1};
      end
      default: begin
        p = '{lo: BLACK, hi: BLACK};
      end
    endcase
    return p;
  endfunction

endpackage

@@ hdl/lpcs_weight.sv @@
// ----------------------------------------------------------------------------
// LED pattern color sampler, weight pipeline
// Four stages: position prep, hash products and table index, hash mix and
// sine table read, noise weight and end color select.
// ----------------------------------------------------------------------------
module lpcs_weight #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [2:0]         sel_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lpcs_pkg::pixel_t   in_data_i,
  output logic               req_valid_o,
  input  logic               req_ready_i,
  output lpcs_pkg::mix_req_t req_o
);

  localparam int KW    = $clog2(SINE_TABLE_DEPTH);
  localparam int ProdW = 16 + $clog2(SINE_TABLE_DEPTH + 1);

  typedef logic [SINE_TABLE_DEPTH-1:0][16:0] sine_tab_t;

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t   tab;
    logic [31:0] ang;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      ang    = 32'((k * 65536) / SINE_TABLE_DEPTH);
      tab[k] = lpcs_pkg::wave_weight(ang[15:0]);
    end
    return tab;
  endfunction

  localparam sine_tab_t SineTab = build_sine_tab();

  logic en1, en2, en3, en4;
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q;

  // stage 1
  logic [2:0]  s1_sel_q;
  logic        s1_upper_q, s1_upper_d;
  logic [16:0] s1_grad_q, s1_grad_d;
  logic [10:0] s1_xi_q, s1_yi_q;
  logic [6:0]  s1_pi_q, s1_pi_d;
  logic [15:0] s1_c_q, s1_c_d;
  logic [16:0] s1_dist_q, s1_dist_d;
  logic [15:0] nx, ny;
  logic [16:0] n16;
  logic [23:0] ph_prod;

  // stage 2
  logic [2:0]       s2_sel_q;
  logic             s2_upper_q;
  logic [16:0]      s2_wt_q, s2_wt_d;
  logic [31:0]      s2_seed_q, s2_seed_d;
  logic [KW-1:0]    s2_k_q;
  logic [ProdW-1:0] k_prod;
  logic [16:0]      dist_inv, wrap_dist;
  logic [19:0]      scaled;
  logic [16:0]      chase_t;

  // stage 3
  logic [2:0]  s3_sel_q;
  logic        s3_upper_q;
  logic [16:0] s3_wt_q, s3_wt_d;
  logic [31:0] s3_seed_q, s3_seed_d;
  logic [31:0] seed_x;

  // stage 4
  lpcs_pkg::mix_req_t    s4_q, s4_d;
  lpcs_pkg::color_pair_t pair;
  logic [7:0]            noise_v;
  logic [16:0]           noise_t;

  assign en4 = !s4_v_q || req_ready_i;
  assign en3 = !s3_v_q || en4;
  assign en2 = !s2_v_q || en3;
  assign en1 = !s1_v_q || en2;
  assign in_ready_o  = en1;
  assign req_valid_o = s4_v_q;
  assign req_o       = s4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      if (en1) s1_v_q <= in_valid_i;
      if (en2) s2_v_q <= s1_v_q;
      if (en3) s3_v_q <= s2_v_q;
      if (en4) s4_v_q <= s3_v_q;
    end
  end

  always_comb begin
    nx = (in_data_i.x_pos > lpcs_pkg::POS_ONE) ? lpcs_pkg::POS_ONE : in_data_i.x_pos;
    ny = (in_data_i.y_pos > lpcs_pkg::POS_ONE) ? lpcs_pkg::POS_ONE : in_data_i.y_pos;
    ph_prod    = 24'(in_data_i.phase) * lpcs_pkg::PHASE_STEPS;
    s1_pi_d    = ph_prod[22:16];
    s1_upper_d = (nx >= lpcs_pkg::POS_HALF);
    s1_grad_d  = s1_upper_d ? 17'({15'(nx - lpcs_pkg::POS_HALF), 2'b00})
                            : {1'b0, nx[13:0], 2'b00};
    s1_c_d     = {nx[13:0], 2'b00} + in_data_i.phase;
    n16        = {nx, 1'b0};
    s1_dist_d  = (n16 >= 17'(in_data_i.phase)) ? 17'(n16 - 17'(in_data_i.phase))
                                                : 17'(17'(in_data_i.phase) - n16);
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_sel_q   <= sel_i;
      s1_upper_q <= s1_upper_d;
      s1_grad_q  <= s1_grad_d;
      s1_xi_q    <= nx[15:5];
      s1_yi_q    <= ny[15:5];
      s1_pi_q    <= s1_pi_d;
      s1_c_q     <= s1_c_d;
      s1_dist_q  <= s1_dist_d;
    end
  end

  always_comb begin
    k_prod    = ProdW'(s1_c_q) * ProdW'(SINE_TABLE_DEPTH);
    s2_seed_d = 32'(32'(s1_xi_q) * lpcs_pkg::HASH_X)
              ^ 32'(32'(s1_yi_q) * lpcs_pkg::HASH_Y)
              ^ 32'(32'(s1_pi_q) * lpcs_pkg::HASH_P);
    dist_inv  = 17'(lpcs_pkg::WEIGHT_ONE - s1_dist_q);
    wrap_dist = (s1_dist_q < dist_inv) ? s1_dist_q : dist_inv;
    scaled    = 20'(wrap_dist) * lpcs_pkg::CHASE_SLOPE;
    chase_t   = (scaled >= 20'(lpcs_pkg::WEIGHT_ONE)) ? 17'd0
              : 17'(20'(lpcs_pkg::WEIGHT_ONE) - scaled);
    s2_wt_d   = (s1_sel_q == lpcs_pkg::PAT_CHASE) ? chase_t : s1_grad_q;
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_sel_q   <= s1_sel_q;
      s2_upper_q <= s1_upper_q;
      s2_wt_q    <= s2_wt_d;
      s2_seed_q  <= s2_seed_d;
      s2_k_q     <= k_prod[16 +: KW];
    end
  end

  always_comb begin
    seed_x    = s2_seed_q ^ (s2_seed_q >> 13);
    s3_seed_d = 32'(seed_x * lpcs_pkg::HASH_MIX);
    s3_wt_d   = (s2_sel_q == lpcs_pkg::PAT_WAVE) ? SineTab[s2_k_q] : s2_wt_q;
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_sel_q   <= s2_sel_q;
      s3_upper_q <= s2_upper_q;
      s3_wt_q    <= s3_wt_d;
      s3_seed_q  <= s3_seed_d;
    end
  end

  // (v*65536+127)/255 == 257*v + (v >= 128)
  always_comb begin
    noise_v     = s3_seed_q[15:8];
    noise_t     = 17'({noise_v, noise_v}) + 17'(noise_v[7]);
    pair        = lpcs_pkg::color_pair(s3_sel_q, s3_upper_q);
    s4_d.lo     = pair.lo;
    s4_d.hi     = pair.hi;
    s4_d.weight = (s3_sel_q == lpcs_pkg::PAT_NOISE) ? noise_t : s3_wt_q;
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      s4_q <= s4_d;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_v_q |-> s4_q.weight <= lpcs_pkg::WEIGHT_ONE)
    else $error("blend weight above one");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q && !en3 |=> s2_v_q && $stable(s2_seed_q) && $stable(s2_wt_q))
    else $error("stalled hash stage lost its item");
`endif

endmodule

@@ hdl/lpcs_mix.sv @@
// ----------------------------------------------------------------------------
// LED pattern color sampler, color mixer
// Two stages: rounded weighted difference per channel, then the final add
// into the output register.
// ----------------------------------------------------------------------------
module lpcs_mix (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  lpcs_pkg::mix_req_t req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lpcs_pkg::color_t   out_data_o
);

  logic en5, en6;
  logic s5_v_q, out_v_q;

  logic [2:0][15:0] lo_ch, hi_ch;
  logic [2:0][15:0] s5_lo_q;
  logic [2:0][15:0] s5_step_q, s5_step_d;
  logic [2:0]       s5_up_q, s5_up_d;
  logic [2:0][15:0] res_d;
  lpcs_pkg::color_t out_q;

  assign en6 = !out_v_q || out_ready_i;
  assign en5 = !s5_v_q || en6;
  assign req_ready_o = en5;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en5) s5_v_q  <= req_valid_i;
      if (en6) out_v_q <= s5_v_q;
    end
  end

  always_comb begin
    logic [15:0] diff;
    logic [31:0] prod;
    lo_ch = {req_i.lo.red, req_i.lo.green, req_i.lo.blue};
    hi_ch = {req_i.hi.red, req_i.hi.green, req_i.hi.blue};
    for (int ch = 0; ch < 3; ch++) begin
      s5_up_d[ch]   = (hi_ch[ch] >= lo_ch[ch]);
      diff          = s5_up_d[ch] ? 16'(hi_ch[ch] - lo_ch[ch]) : 16'(lo_ch[ch] - hi_ch[ch]);
      prod          = 32'(32'(diff) * 32'(req_i.weight)) + 32'd32768;
      s5_step_d[ch] = prod[31:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      s5_lo_q   <= lo_ch;
      s5_up_q   <= s5_up_d;
      s5_step_q <= s5_step_d;
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      res_d[ch] = s5_up_q[ch] ? 16'(s5_lo_q[ch] + s5_step_q[ch])
                              : 16'(s5_lo_q[ch] - s5_step_q[ch]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en6) begin
      out_q.red   <= res_d[2];
      out_q.green <= res_d[1];
      out_q.blue  <= res_d[0];
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s5_v_q |-> (s5_up_q[2] ? (17'(s5_lo_q[2]) + 17'(s5_step_q[2]) <= 17'd65535)
                           : (s5_step_q[2] <= s5_lo_q[2])))
    else $error("red mix leaves the color range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s5_v_q && !en6 |=> s5_v_q && $stable(s5_step_q) && $stable(s5_lo_q))
    else $error("stalled mix stage lost its item");
`endif

endmodule

@@ hdl/led_pattern_color_sampler_unit.sv @@
// ----------------------------------------------------------------------------
// LED pattern color sampler
// Maps a fixture position and animation phase to an RGB color using the
// configured pattern: solid, gradient, sine wave, hashed noise or chase.
//
//   channel   signals                         payload
//   in        in_valid_i / in_ready_o         in_data_i   (pixel_t)
//   out       out_valid_o / out_ready_i       out_data_o  (color_t)
//   cfg       cfg_valid_i / cfg_ready_o       cfg_data_i  (pattern, 3 bits)
//
// One item per cycle while the output is not stalled.
// Each item passes the six register stages: prep, hash products, hash mix
// and sine table, weight select, channel multiply, final add.
// A stall at the output holds every full stage; empty stages keep filling.
// Reset clears all valid bits and selects the solid pattern.
// ----------------------------------------------------------------------------
module led_pattern_color_sampler_unit #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lpcs_pkg::pixel_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lpcs_pkg::color_t out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_data_i
);

  logic [2:0]         sel_q;
  logic               req_valid, req_ready;
  lpcs_pkg::mix_req_t req;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 3'(lpcs_pkg::PAT_SOLID);
    end else if (cfg_valid_i) begin
      sel_q <= cfg_data_i;
    end
  end

  lpcs_weight #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_weight (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sel_i       (sel_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .req_valid_o (req_valid),
    .req_ready_i (req_ready),
    .req_o       (req)
  );

  lpcs_mix u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input blocked without an output stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && !req_ready |-> out_valid_o && !out_ready_i)
    else $error("mixer stalled without an output stall");
`endif

endmodule
